### src/nfa_pkg.sv
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared constants and operation codes for the next-fit identifier allocator.
// ----------------------------------------------------------------------------
package nfa_pkg;

  localparam int ID_W     = 32;
  localparam int OP_W     = 3;
  localparam int SCNT_W   = 9;
  localparam int OUT_TD_W = 40;

  localparam int SLOTS_DEF = 256;

  localparam logic [SCNT_W-1:0] SCNT_RST = 9'd256;

  // Operation codes carried on the input side-band.
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OP_W-1:0] OP_CAPTURE = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd3;
  localparam logic [OP_W-1:0] OP_REL_ALL = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_BASE_ID    = 1'b0;
  localparam logic CFG_SLOT_COUNT = 1'b1;

endpackage

### src/nfa_ram.sv
// ----------------------------------------------------------------------------
// nfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nfa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/next_fit_id_allocator.sv
// ----------------------------------------------------------------------------
// next_fit_id_allocator
// Bitmap identifier allocator with a next-fit scan pointer.
// ----------------------------------------------------------------------------
// The block handles one item at a time. Release and unknown operations pass
// through decode and execute to the done state, where the result is offered.
// Capture and query of an id in range first read the occupancy RAM in a look
// state. Allocate walks the occupancy RAM one slot per cycle from the scan
// pointer and examines at most n slots, where n is the active slot count (at
// most SLOTS). Release all with a nonzero slot count, and every configuration
// write, sweep the whole occupancy RAM one slot a cycle; release all offers
// its result once its sweep is over. The same sweep runs after reset, and no
// item is taken until it is over. A finished result waits in an output
// register, so the next item is accepted the cycle after that register is
// loaded, while the previous result is still pending. A second finished
// result then holds the block until the first leaves.
module next_fit_id_allocator
  import nfa_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input item: tuser[2:0] opcode; tdata[31:0] id.
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [ID_W-1:0]     in_tdata,
  input  logic [OP_W-1:0]     in_tuser,
  // Result item: tdata[31:0] result_id, [32] ok, [33] captured, [39:34] zero.
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_TD_W-1:0] out_tdata,
  // Configuration write port.
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [ID_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_LOOK   = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]          state_r,    state_nxt;
  logic [OP_W-1:0]     op_r,       op_nxt;
  logic [ID_W-1:0]     id_r,       id_nxt;
  logic [ID_W-1:0]     base_r,     base_nxt;
  logic [SCNT_W-1:0]   scnt_r,     scnt_nxt;
  logic [IDX_W-1:0]    ptr_r,      ptr_nxt;
  logic                rng_r,      rng_nxt;
  logic [IDX_W-1:0]    slot_r,     slot_nxt;
  logic [IDX_W-1:0]    iss_slot_r, iss_slot_nxt;
  logic [CNT_W-1:0]    iss_cnt_r,  iss_cnt_nxt;
  logic                chk_vld_r,  chk_vld_nxt;
  logic [IDX_W-1:0]    chk_slot_r, chk_slot_nxt;
  logic [IDX_W-1:0]    clr_addr_r, clr_addr_nxt;
  logic                clr_op_r,   clr_op_nxt;
  logic [ID_W-1:0]     res_id_r,   res_id_nxt;
  logic                res_ok_r,   res_ok_nxt;
  logic                res_cap_r,  res_cap_nxt;
  logic                out_vld_r,  out_vld_nxt;
  logic [OUT_TD_W-1:0] out_data_r, out_data_nxt;

  logic [CNT_W-1:0] n_act;
  logic [ID_W:0]    diff;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic             ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic             ram_rdata;
  logic             issue;
  logic             start_ovf;
  logic             ptr_wrap;

  // Active slot count saturates at the size of the map.
  assign n_act = ({{(32-SCNT_W){1'b0}}, scnt_r} > 32'(SLOTS)) ? CNT_W'(SLOTS)
                                                              : CNT_W'(scnt_r);

  assign diff      = {1'b0, id_r} - {1'b0, base_r};
  assign issue     = (iss_cnt_r != n_act);
  assign start_ovf = (CNT_W'(ptr_r) >= n_act);
  assign ptr_wrap  = ((CNT_W'(ptr_r) + CNT_W'(1)) == n_act);
  assign ram_raddr = (state_r == S_SCAN) ? iss_slot_r : slot_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  nfa_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    id_nxt       = id_r;
    base_nxt     = base_r;
    scnt_nxt     = scnt_r;
    ptr_nxt      = ptr_r;
    rng_nxt      = rng_r;
    slot_nxt     = slot_r;
    iss_slot_nxt = iss_slot_r;
    iss_cnt_nxt  = iss_cnt_r;
    chk_vld_nxt  = chk_vld_r;
    chk_slot_nxt = chk_slot_r;
    clr_addr_nxt = clr_addr_r;
    clr_op_nxt   = clr_op_r;
    res_id_nxt   = res_id_r;
    res_ok_nxt   = res_ok_r;
    res_cap_nxt  = res_cap_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    ram_we       = 1'b0;
    ram_waddr    = slot_r;
    ram_wdata    = 1'b0;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = 1'b0;
        clr_addr_nxt = clr_addr_r + IDX_W'(1);
        if (clr_addr_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = clr_op_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          id_nxt    = in_tdata;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        rng_nxt     = !diff[ID_W] && (diff[ID_W-1:0] < 32'(n_act));
        slot_nxt    = diff[IDX_W-1:0];
        res_id_nxt  = id_r;
        res_ok_nxt  = 1'b0;
        res_cap_nxt = 1'b0;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (op_r)
          OP_ALLOC: begin
            res_id_nxt = '1;
            if (n_act != '0) begin
              // The scan starts at the pointer, pulled back into range.
              ptr_nxt      = start_ovf ? '0 : ptr_r;
              iss_slot_nxt = start_ovf ? '0 : ptr_r;
              iss_cnt_nxt  = '0;
              chk_vld_nxt  = 1'b0;
              state_nxt    = S_SCAN;
            end
          end
          OP_CAPTURE, OP_QUERY: begin
            if (rng_r) begin
              state_nxt = S_LOOK;
            end
          end
          OP_RELEASE: begin
            if (rng_r) begin
              ram_we     = 1'b1;
              ram_waddr  = slot_r;
              ram_wdata  = 1'b0;
              res_ok_nxt = 1'b1;
            end
          end
          OP_REL_ALL: begin
            if (n_act != '0) begin
              res_ok_nxt   = 1'b1;
              clr_addr_nxt = '0;
              clr_op_nxt   = 1'b1;
              state_nxt    = S_CLEAR;
            end
          end
          default: begin
          end
        endcase
      end
      S_LOOK: begin
        state_nxt = S_DONE;
        if (op_r == OP_CAPTURE) begin
          if (!ram_rdata) begin
            ram_we     = 1'b1;
            ram_waddr  = slot_r;
            ram_wdata  = 1'b1;
            res_ok_nxt = 1'b1;
          end
        end else begin
          res_ok_nxt  = 1'b1;
          res_cap_nxt = ram_rdata;
        end
      end
      S_SCAN: begin
        // One slot is read per cycle; its bit is checked in the next cycle.
        chk_vld_nxt  = issue;
        chk_slot_nxt = iss_slot_r;
        if (issue) begin
          iss_cnt_nxt  = iss_cnt_r + CNT_W'(1);
          iss_slot_nxt = ((CNT_W'(iss_slot_r) + CNT_W'(1)) == n_act) ? '0
                                                                     : iss_slot_r + IDX_W'(1);
        end
        if (chk_vld_r && !ram_rdata) begin
          ram_we     = 1'b1;
          ram_waddr  = chk_slot_r;
          ram_wdata  = 1'b1;
          ptr_nxt    = chk_slot_r;
          res_id_nxt = base_r + ID_W'(chk_slot_r);
          res_ok_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else if (chk_vld_r && !issue) begin
          // Every slot was held: the pointer moves on by one.
          ptr_nxt   = ptr_wrap ? '0 : ptr_r + IDX_W'(1);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        clr_op_nxt = 1'b0;
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {{(OUT_TD_W-ID_W-2){1'b0}}, res_cap_r, res_ok_r, res_id_r};
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A register write clears the map and the pointer.
    if (cfg_we) begin
      if (cfg_addr == CFG_BASE_ID) begin
        base_nxt = cfg_wdata;
      end else begin
        scnt_nxt = cfg_wdata[SCNT_W-1:0];
      end
      ptr_nxt      = '0;
      clr_addr_nxt = '0;
      clr_op_nxt   = 1'b0;
      state_nxt    = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      base_r     <= '0;
      scnt_r     <= SCNT_RST;
      ptr_r      <= '0;
      clr_addr_r <= '0;
      clr_op_r   <= 1'b0;
      chk_vld_r  <= 1'b0;
      iss_cnt_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      base_r     <= base_nxt;
      scnt_r     <= scnt_nxt;
      ptr_r      <= ptr_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_op_r   <= clr_op_nxt;
      chk_vld_r  <= chk_vld_nxt;
      iss_cnt_r  <= iss_cnt_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    rng_r      <= rng_nxt;
    slot_r     <= slot_nxt;
    iss_slot_r <= iss_slot_nxt;
    chk_slot_r <= chk_slot_nxt;
    res_id_r   <= res_id_nxt;
    res_ok_r   <= res_ok_nxt;
    res_cap_r  <= res_cap_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### tb/nfa_reply_checker.sv
// ----------------------------------------------------------------------------
// nfa_reply_checker
// Watches the item, result and register-write traffic of the identifier
// allocator, keeps its own occupancy map and scan pointer, works out the
// result of every accepted item and compares it with what the block returns.
// ----------------------------------------------------------------------------
module nfa_reply_checker
  import nfa_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [ID_W-1:0]     in_tdata,      // [31:0] id
  input  logic [OP_W-1:0]     in_tuser,      // [2:0] opcode
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OUT_TD_W-1:0] out_tdata,     // [31:0] result_id, [32] ok, [33] captured
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [ID_W-1:0]     cfg_wdata,
  output int                  mismatches,
  output int                  outstanding,
  output int                  replies_seen,
  output int                  grants,
  output int                  full_refusals
);

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    logic            ok;
    logic            captured;
  } id_reply_t;

  logic [ID_W-1:0]   base_id = '0;
  logic [SCNT_W-1:0] slot_count = SCNT_RST;
  bit                held [SLOTS];
  int unsigned       scan_ptr = 0;
  id_reply_t         awaited [$];
  int                errs = 0;
  int                seen = 0;
  int                granted = 0;
  int                refused = 0;

  function automatic int unsigned live_slots();
    return (slot_count > SLOTS) ? SLOTS : slot_count;
  endfunction

  function automatic void forget_all();
    foreach (held[k]) held[k] = 1'b0;
    scan_ptr = 0;
  endfunction

  // The range ends at the top of the 32-bit space even when base plus count
  // would run past it.
  function automatic bit locate(input logic [ID_W-1:0] id, output int unsigned slot);
    logic [ID_W-1:0] off;
    off  = id - base_id;
    slot = off;
    return (id >= base_id) && (off < live_slots());
  endfunction

  function automatic id_reply_t apply_op(input logic [OP_W-1:0] op,
                                         input logic [ID_W-1:0] id);
    id_reply_t   r;
    int unsigned n;
    int unsigned slot;
    int unsigned s;
    int unsigned i;
    bit          hit;
    bit          found;
    n           = live_slots();
    r.result_id = id;
    r.ok        = 1'b0;
    r.captured  = 1'b0;
    found       = 1'b0;
    slot        = 0;
    case (op)
      OP_ALLOC: begin
        r.result_id = '1;
        if (n != 0) begin
          if (scan_ptr >= n) scan_ptr = 0;
          for (i = 0; i < n; i++) begin
            s = scan_ptr + i;
            if (s >= n) s -= n;
            if (!found && !held[s]) begin
              found       = 1'b1;
              held[s]     = 1'b1;
              slot        = s;
              r.result_id = base_id + s;
              r.ok        = 1'b1;
            end
          end
          // A full map still moves the pointer on by one slot.
          if (found) scan_ptr = slot;
          else scan_ptr = (scan_ptr + 1 >= n) ? 0 : scan_ptr + 1;
        end
      end
      OP_CAPTURE: begin
        hit = locate(id, slot);
        if (hit) begin
          if (!held[slot]) begin
            held[slot] = 1'b1;
            r.ok       = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        hit = locate(id, slot);
        if (hit) begin
          held[slot] = 1'b0;
          r.ok       = 1'b1;
        end
      end
      OP_QUERY: begin
        hit = locate(id, slot);
        if (hit) begin
          r.ok       = 1'b1;
          r.captured = held[slot];
        end
      end
      OP_REL_ALL: begin
        if (n != 0) begin
          foreach (held[k]) held[k] = 1'b0;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    id_reply_t want;
    id_reply_t got;
    if (!rst_n) begin
      base_id    = '0;
      slot_count = SCNT_RST;
      forget_all();
      awaited.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen++;
        if (awaited.size() == 0) begin
          errs++;
          $display("%0t: result item with none awaited: expected nothing, actual %h",
                   $time, out_tdata);
        end else begin
          want = awaited.pop_front();
          if (out_tdata[ID_W-1:0] !== want.result_id) begin
            errs++;
            $display("%0t: result_id expected %h, actual %h",
                     $time, want.result_id, out_tdata[ID_W-1:0]);
          end
          if (out_tdata[ID_W] !== want.ok) begin
            errs++;
            $display("%0t: ok expected %b, actual %b (result_id %h)",
                     $time, want.ok, out_tdata[ID_W], want.result_id);
          end
          if (out_tdata[ID_W+1] !== want.captured) begin
            errs++;
            $display("%0t: captured expected %b, actual %b (result_id %h)",
                     $time, want.captured, out_tdata[ID_W+1], want.result_id);
          end
          if (out_tdata[OUT_TD_W-1:ID_W+2] !== '0) begin
            errs++;
            $display("%0t: padding expected 0, actual %h",
                     $time, out_tdata[OUT_TD_W-1:ID_W+2]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        got = apply_op(in_tuser, in_tdata);
        if (in_tuser == OP_ALLOC && got.ok) granted++;
        if (in_tuser == OP_ALLOC && !got.ok && live_slots() != 0) refused++;
        awaited.push_back(got);
      end
      if (cfg_we) begin
        if (cfg_addr == CFG_BASE_ID) base_id = cfg_wdata;
        else slot_count = cfg_wdata[SCNT_W-1:0];
        forget_all();
      end
    end
    mismatches    <= errs;
    outstanding   <= awaited.size();
    replies_seen  <= seen;
    grants        <= granted;
    full_refusals <= refused;
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the next-fit identifier allocator. A directed
// opening walks every operation and the corner cases of the id range, then
// random traffic runs under a series of base and slot-count settings with
// random gaps and stalls on both streams; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb;
  import nfa_pkg::*;

  localparam int SETTLE    = 300;   // covers the full-map sweep after a write
  localparam int LONG_HOLD = 400;
  localparam int WATCHDOG  = 4000;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [ID_W-1:0]     in_tdata = '0;   // [31:0] id
  logic [OP_W-1:0]     in_tuser = OP_ALLOC;   // [2:0] opcode
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_TD_W-1:0] out_tdata;       // [31:0] result_id, [32] ok, [33] captured
  logic                cfg_we = 1'b0;
  logic                cfg_addr = CFG_BASE_ID;
  logic [ID_W-1:0]     cfg_wdata = '0;

  int              mismatches;
  int              outstanding;
  int              replies_seen;
  int              grants;
  int              full_refusals;
  bit              no_idle = 1'b0;
  int              hold_requests = 0;
  int unsigned     quiet_cycles = 0;
  logic [ID_W-1:0] cur_base = '0;
  int unsigned     cur_slots = SLOTS_DEF;
  int              settings_done = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  next_fit_id_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  nfa_reply_checker reply_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .replies_seen (replies_seen),
    .grants       (grants),
    .full_refusals(full_refusals)
  );

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Result side: a random stall before each item, none inside burst windows,
  // and one long hold-off whenever the stimulus asks for it.
  initial begin : result_sink
    int stall;
    int holds_served;
    holds_served = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_requests != holds_served) begin
        holds_served++;
        stall = LONG_HOLD;
      end else if (no_idle) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 14);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= id;
    in_tuser  <= op;
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  task automatic pause_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [ID_W-1:0] value);
    pause_for_results();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input logic [ID_W-1:0] base, input logic [ID_W-1:0] count_word);
    write_reg(CFG_BASE_ID, base);
    write_reg(CFG_SLOT_COUNT, count_word);
    cur_base  = base;
    cur_slots = (count_word[SCNT_W-1:0] > SLOTS_DEF) ? SLOTS_DEF : count_word[SCNT_W-1:0];
    settings_done++;
  endtask

  // Bits above the slot-count register are random so that every data bit moves.
  function automatic logic [ID_W-1:0] with_junk(input logic [SCNT_W-1:0] c);
    logic [ID_W-1:0] w;
    w             = $urandom();
    w[SCNT_W-1:0] = c;
    return w;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int unsigned span;
    span = (cur_slots == 0) ? 1 : cur_slots;
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return cur_base - 1 - $urandom_range(0, 2);
      2:       return cur_base + cur_slots + $urandom_range(0, 2);
      default: return cur_base + $urandom_range(0, span - 1);
    endcase
  endfunction

  task automatic run_chunk(input int items, input int alloc_pct, input bit long_hold,
                           input bit mid_pause);
    int              i;
    int              roll;
    int              pick;
    logic [OP_W-1:0] op;
    for (i = 0; i < items; i++) begin
      no_idle <= (i >= items / 2 && i < items / 2 + items / 5) ||
                 (long_hold && i >= items / 4 && i < items / 4 + 40);
      if (long_hold && i == items / 4) hold_requests <= hold_requests + 1;
      if (mid_pause && i == items * 3 / 4) pause_for_results();
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 19);
      if (roll < alloc_pct) begin
        op = OP_ALLOC;
      end else if (pick < 8) begin
        op = OP_RELEASE;
      end else if (pick < 13) begin
        op = OP_QUERY;
      end else if (pick < 18) begin
        op = OP_CAPTURE;
      end else if (pick == 18) begin
        op = OP_REL_ALL;
      end else begin
        op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      send_item(op, (op == OP_ALLOC) ? $urandom() : pick_id());
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: base 0, all 256 slots.
    send_item(OP_ALLOC, 32'h0000_0000);
    send_item(OP_ALLOC, 32'hFFFF_FFFF);     // pointer sits on slot 0, so slot 1 is next
    send_item(OP_CAPTURE, 32'd5);
    send_item(OP_CAPTURE, 32'd5);           // already held
    send_item(OP_CAPTURE, 32'd256);         // one past the range must be refused
    send_item(OP_QUERY, 32'd5);
    send_item(OP_QUERY, 32'd7);
    send_item(OP_QUERY, 32'hFFFF_FFFF);
    send_item(OP_RELEASE, 32'd5);
    send_item(OP_RELEASE, 32'd5);           // releasing a free slot is still acknowledged
    send_item(OP_RELEASE, 32'd256);
    send_item(OP_REL_ALL, 32'h0000_0000);
    send_item(OP_SPARE_LO, 32'hA5A5_A5A5);
    send_item(OP_SPARE_HI, 32'h5A5A_5A5A);

    // A range that runs off the top of the id space, then a full map.
    apply_setting(32'hFFFF_FFFE, 32'd4);
    repeat (5) send_item(OP_ALLOC, $urandom());
    send_item(OP_QUERY, 32'h0000_0000);
    send_item(OP_CAPTURE, 32'hFFFF_FFFF);
    send_item(OP_RELEASE, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 32'h0000_0000);

    // Only bit 9 set, which the register drops, so the allocator is disabled.
    apply_setting(32'h0000_0010, 32'h0000_0200);
    send_item(OP_ALLOC, 32'h0000_0010);
    send_item(OP_CAPTURE, 32'h0000_0010);
    send_item(OP_QUERY, 32'h0000_0010);
    send_item(OP_REL_ALL, 32'h0000_0000);

    apply_setting(32'h0000_0000, with_junk(9'd256));
    run_chunk(300, 60, 1'b1, 1'b0);
    apply_setting(32'hFFFF_FFFF, with_junk(9'd1));
    run_chunk(120, 40, 1'b0, 1'b0);
    apply_setting(32'hFFFF_FF80, with_junk(9'd256));
    run_chunk(250, 60, 1'b0, 1'b1);
    apply_setting($urandom(), with_junk(9'd5));
    run_chunk(150, 40, 1'b1, 1'b0);
    apply_setting($urandom(), with_junk(9'd511));
    run_chunk(150, 50, 1'b0, 1'b0);
    apply_setting($urandom(), with_junk(9'd0));
    run_chunk(40, 40, 1'b0, 1'b0);
    apply_setting($urandom(), with_junk(SCNT_W'($urandom_range(1, 64))));
    run_chunk(200, 45, 1'b0, 1'b1);
    apply_setting($urandom(), with_junk(SCNT_W'($urandom_range(1, 511))));
    run_chunk(140, 45, 1'b0, 1'b0);

    pause_for_results();
    repeat (SETTLE) @(posedge clk);
    $display("tb: %0d results compared across %0d register settings, %0d ids granted,",
             replies_seen, settings_done + 1, grants);
    $display("tb: %0d allocations refused on a full map; slot counts 0, 1, small, 256, saturated",
             full_refusals);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### files.f
src/nfa_pkg.sv
src/nfa_ram.sv
src/next_fit_id_allocator.sv
tb/nfa_reply_checker.sv
tb/tb.sv
